[src/assert_macros.svh]
// Assertion macros shared by the swept box intersection RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define SAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/sad_pkg.sv]
// Package for the swept box intersection core: default widths, register map
// and the per-axis flag bundle. No dependencies.
package sad_pkg;

  localparam int COORD_BITS_DEF     = 16;
  localparam int TIME_FRAC_BITS_DEF = 16;
  localparam int CFG_ADDR_W         = 5;
  localparam int CFG_DATA_W         = 32;

  typedef enum logic [2:0] {
    REG_A_CENTER_X = 3'd0,
    REG_A_CENTER_Y = 3'd1,
    REG_A_CENTER_Z = 3'd2,
    REG_A_HALF_X   = 3'd3,
    REG_A_HALF_Y   = 3'd4,
    REG_A_HALF_Z   = 3'd5
  } sad_reg_t;

  // Per-axis decisions made before the divide.
  typedef struct packed {
    logic ovl;   // boxes overlap or touch on this axis
    logic fail;  // separated and not closing in
    logic c0;    // axis clips the entry time
    logic c1;    // axis clips the exit time
    logic sat0;  // entry quotient reaches 1.0
    logic sat1;  // exit quotient reaches 1.0
  } sad_flags_t;

endpackage

[src/sad_div.sv]
// Pipelined restoring divider producing the fraction bits of num/den, num < den.
// One quotient bit per stage. Uses sad_pkg.
module sad_div import sad_pkg::*; #(
  parameter int DEN_W = COORD_BITS_DEF,
  parameter int FRAC  = TIME_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [FRAC-1:0]  quo_o
);

  logic [DEN_W-1:0] rem_r [FRAC];
  logic [DEN_W-1:0] den_r [FRAC];
  logic [FRAC-1:0]  quo_r [FRAC];

  genvar k;
  for (k = 0; k < FRAC; k++) begin : g_stg
    logic [DEN_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [FRAC-1:0]  q_in;
    logic [DEN_W:0]   r2;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_r[k-1];
      assign d_in = den_r[k-1];
      assign q_in = quo_r[k-1];
    end

    assign r2 = {r_in, 1'b0};
    assign ge = (r2 >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DEN_W'(r2 - {1'b0, d_in}) : r2[DEN_W-1:0];
        den_r[k] <= d_in;
        quo_r[k] <= {q_in[FRAC-2:0], ge};
      end
    end
  end

  assign quo_o = quo_r[FRAC-1];

endmodule

[src/sad_lane.sv]
// One axis of the swept box test: bounds, clip decisions and two dividers.
// Uses sad_pkg and sad_div.
module sad_lane import sad_pkg::*; #(
  parameter int CB = COORD_BITS_DEF,
  parameter int F  = TIME_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  logic [CB-1:0] a_c,
  input  logic [CB-2:0] a_h,
  input  logic [CB-1:0] b_c,
  input  logic [CB-2:0] b_h,
  input  logic [CB-1:0] vel,
  output sad_flags_t    flg_o,
  output logic [F:0]    t0_o,
  output logic [F:0]    t1_o
);

  localparam int BW = CB + 1;
  localparam int GW = CB + 2;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  logic signed [BW-1:0] amin, amax, bmin, bmax;
  logic signed [GW-1:0] g0, g1;
  logic                 neg, pos;
  logic                 b_below, b_above;
  logic [CB-1:0]        spd;
  sad_flags_t           flg_nxt;
  sad_flags_t           flg_r [F+1];
  logic [CB-1:0]        num0_r, num1_r, spd_r;
  logic [F-1:0]         q0, q1;

  assign amin = $signed({a_c[CB-1], a_c}) - $signed({2'b00, a_h});
  assign amax = $signed({a_c[CB-1], a_c}) + $signed({2'b00, a_h});
  assign bmin = $signed({b_c[CB-1], b_c}) - $signed({2'b00, b_h});
  assign bmax = $signed({b_c[CB-1], b_c}) + $signed({2'b00, b_h});

  assign neg     = vel[CB-1];
  assign pos     = !neg && (vel != '0);
  assign b_below = bmax < amin;
  assign b_above = bmin > amax;
  assign spd     = neg ? CB'(~vel + 1'b1) : vel;

  // Entry and exit gaps, oriented by the direction of travel.
  always_comb begin
    if (neg) begin
      g0 = GW'(bmin) - GW'(amax);
      g1 = GW'(bmax) - GW'(amin);
    end else begin
      g0 = GW'(amin) - GW'(bmax);
      g1 = GW'(amax) - GW'(bmin);
    end
    flg_nxt.ovl  = !b_below && !b_above;
    flg_nxt.fail = neg ? b_below : (pos ? b_above : (b_below || b_above));
    flg_nxt.c0   = neg ? b_above : (pos ? b_below : 1'b0);
    flg_nxt.c1   = neg ? (bmax > amin) : (pos ? (amax > bmin) : 1'b0);
    flg_nxt.sat0 = g0 >= $signed({2'b00, spd});
    flg_nxt.sat1 = g1 >= $signed({2'b00, spd});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flg_r[0] <= flg_nxt;
      num0_r   <= g0[CB-1:0];
      num1_r   <= g1[CB-1:0];
      spd_r    <= spd;
      for (int i = 1; i <= F; i++) begin
        flg_r[i] <= flg_r[i-1];
      end
    end
  end

  sad_div #(.DEN_W(CB), .FRAC(F)) u_div0 (
    .clk(clk), .en(en), .num_i(num0_r), .den_i(spd_r), .quo_o(q0)
  );

  sad_div #(.DEN_W(CB), .FRAC(F)) u_div1 (
    .clk(clk), .en(en), .num_i(num1_r), .den_i(spd_r), .quo_o(q1)
  );

  assign flg_o = flg_r[F];
  assign t0_o  = !flg_r[F].c0 ? '0  : (flg_r[F].sat0 ? ONE : {1'b0, q0});
  assign t1_o  = !flg_r[F].c1 ? ONE : (flg_r[F].sat1 ? ONE : {1'b0, q1});

endmodule

[src/sad_merge.sv]
// Combines the three axis results into hit and contact times, and holds the
// output register. Uses sad_pkg.
module sad_merge import sad_pkg::*; #(
  parameter int F = TIME_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       vld_i,
  input  sad_flags_t flg_i [3],
  input  logic [F:0] t0_i  [3],
  input  logic [F:0] t1_i  [3],
  output logic       vld_o,
  output logic       hit_o,
  output logic [F:0] tf_o,
  output logic [F:0] tl_o
);

  logic       vld_r, hit_r, hit_nxt;
  logic [F:0] tf_r, tl_r, tf_nxt, tl_nxt;
  logic [F:0] t0m, t0max, t1m, t1min;

  always_comb begin
    t0m   = (t0_i[0] > t0_i[1]) ? t0_i[0] : t0_i[1];
    t0max = (t0m > t0_i[2]) ? t0m : t0_i[2];
    t1m   = (t1_i[0] < t1_i[1]) ? t1_i[0] : t1_i[1];
    t1min = (t1m < t1_i[2]) ? t1m : t1_i[2];
    hit_nxt = 1'b0;
    tf_nxt  = '0;
    tl_nxt  = '0;
    priority if (flg_i[0].ovl && flg_i[1].ovl && flg_i[2].ovl) begin
      hit_nxt = 1'b1;
    end else if (flg_i[0].fail || flg_i[1].fail || flg_i[2].fail || (t0max > t1min)) begin
      hit_nxt = 1'b0;
    end else begin
      hit_nxt = 1'b1;
      tf_nxt  = t0max;
      tl_nxt  = t1min;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
      tf_r  <= tf_nxt;
      tl_r  <= tl_nxt;
    end
  end

  assign vld_o = vld_r;
  assign hit_o = hit_r;
  assign tf_o  = tf_r;
  assign tl_o  = tl_r;

endmodule

[src/swept_aabb_intersection_core.sv]
// Swept box intersection core: an input transfer passes through the lane input
// registers, the divider stages and the merge output register to the result.
// Throughput is one item per cycle while the sink takes results; the per-axis
// dividers are fully pipelined, one quotient bit per stage, and the whole
// pipeline advances together. Reset (synchronous, rst_n low) empties the
// pipeline and clears the box A registers to zero.
`include "assert_macros.svh"

module swept_aabb_intersection_core import sad_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream. tdata, lowest bit up: b_center_x, b_center_y, b_center_z,
  // b_half_x, b_half_y, b_half_z, rel_vel_x, rel_vel_y, rel_vel_z, zero pad.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [((9*COORD_BITS-3+7)/8)*8-1:0] in_tdata,
  // Result stream. tdata, lowest bit up: hit, t_first, t_last, zero pad.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [((2*TIME_FRAC_BITS+3+7)/8)*8-1:0] out_tdata,
  // Configuration port, one register every four bytes.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int CB    = COORD_BITS;
  localparam int F     = TIME_FRAC_BITS;
  localparam int IN_W  = ((9*CB-3+7)/8)*8;
  localparam int OUT_W = ((2*F+3+7)/8)*8;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  // Box A registers.
  logic [CB-1:0] a_c_r [3];
  logic [CB-2:0] a_h_r [3];
  logic          cfg_wr;
  sad_reg_t      cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = sad_reg_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        a_c_r[i] <= '0;
        a_h_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_A_CENTER_X: a_c_r[0] <= cfg_pwdata[CB-1:0];
        REG_A_CENTER_Y: a_c_r[1] <= cfg_pwdata[CB-1:0];
        REG_A_CENTER_Z: a_c_r[2] <= cfg_pwdata[CB-1:0];
        REG_A_HALF_X:   a_h_r[0] <= cfg_pwdata[CB-2:0];
        REG_A_HALF_Y:   a_h_r[1] <= cfg_pwdata[CB-2:0];
        REG_A_HALF_Z:   a_h_r[2] <= cfg_pwdata[CB-2:0];
        default: ;
      endcase
    end
  end

  // Read-back sign-extends the centers and zero-extends the half extents.
  always_comb begin
    unique case (cfg_sel)
      REG_A_CENTER_X: cfg_prdata = CFG_DATA_W'($signed(a_c_r[0]));
      REG_A_CENTER_Y: cfg_prdata = CFG_DATA_W'($signed(a_c_r[1]));
      REG_A_CENTER_Z: cfg_prdata = CFG_DATA_W'($signed(a_c_r[2]));
      REG_A_HALF_X:   cfg_prdata = CFG_DATA_W'(a_h_r[0]);
      REG_A_HALF_Y:   cfg_prdata = CFG_DATA_W'(a_h_r[1]);
      REG_A_HALF_Z:   cfg_prdata = CFG_DATA_W'(a_h_r[2]);
      default:        cfg_prdata = '0;
    endcase
  end

  // The whole pipeline moves as one; it stalls only when the output register
  // holds a result that the sink has not taken.
  logic en;
  logic in_xfer;
  logic vld_r [F+1];
  logic out_vld;

  assign en        = !out_vld || out_tready;
  assign in_tready = en;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= F; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_xfer;
      for (int i = 1; i <= F; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Unpack the input transfer into per-axis fields.
  logic [CB-1:0] b_c [3];
  logic [CB-2:0] b_h [3];
  logic [CB-1:0] vel [3];
  logic [IN_W-1:0] in_pad_unused;

  for (genvar a = 0; a < 3; a++) begin : g_unpack
    assign b_c[a] = in_tdata[a*CB +: CB];
    assign b_h[a] = in_tdata[3*CB + a*(CB-1) +: CB-1];
    assign vel[a] = in_tdata[3*CB + 3*(CB-1) + a*CB +: CB];
  end
  assign in_pad_unused = in_tdata;

  // One lane per axis; each holds its own pair of dividers.
  sad_flags_t lane_flg [3];
  logic [F:0] lane_t0  [3];
  logic [F:0] lane_t1  [3];

  for (genvar a = 0; a < 3; a++) begin : g_lane
    sad_lane #(.CB(CB), .F(F)) u_lane (
      .clk   (clk),
      .en    (en),
      .a_c   (a_c_r[a]),
      .a_h   (a_h_r[a]),
      .b_c   (b_c[a]),
      .b_h   (b_h[a]),
      .vel   (vel[a]),
      .flg_o (lane_flg[a]),
      .t0_o  (lane_t0[a]),
      .t1_o  (lane_t1[a])
    );
  end

  logic       hit;
  logic [F:0] t_first, t_last;

  sad_merge #(.F(F)) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vld_r[F]),
    .flg_i (lane_flg),
    .t0_i  (lane_t0),
    .t1_i  (lane_t1),
    .vld_o (out_vld),
    .hit_o (hit),
    .tf_o  (t_first),
    .tl_o  (t_last)
  );

  assign out_tvalid = out_vld;
  assign out_tdata  = OUT_W'({t_last, t_first, hit});

  // A miss always reports both times as zero.
  `SAD_ASSERT(a_miss_zero, (out_vld && !hit) |-> (t_first == '0 && t_last == '0),
              "miss with nonzero times")
  // A reported contact interval is ordered and within one time unit.
  `SAD_ASSERT(a_hit_order, (out_vld && hit) |-> (t_first <= t_last && t_last <= ONE),
              "bad contact interval")
  // An item leaving the last divider stage lands in the output register.
  `SAD_ASSERT_NEXT(a_drain, (vld_r[F] && en), out_vld, "result lost at output register")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for swept_aabb_intersection_core: streams random and
// directed moving boxes against configured box A and checks every result.
// Depends on sad_pkg and the core RTL only.
module tb_top;
  import sad_pkg::*;

  localparam int  IN_W     = 144;
  localparam int  OUT_W    = 40;
  localparam longint TIME_ONE = 64'd65536;
  localparam int  WATCHDOG_LIMIT = 5000;
  localparam int  DRAIN_CYCLES   = 40;

  // One moving box B with its relative displacement per time unit.
  typedef struct {
    logic signed [15:0] ctr[3];
    logic        [14:0] half[3];
    logic signed [15:0] vel[3];
  } box_in_t;

  // Expected contact report.
  typedef struct packed {
    logic        hit;
    logic [16:0] t_first;
    logic [16:0] t_last;
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // Fields, lowest bit up: b_center_x/y/z, b_half_x/y/z, rel_vel_x/y/z, zero pad.
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // Fields, lowest bit up: hit, t_first, t_last, zero pad.
  logic [OUT_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // Our own copy of the box A registers, updated on every register write.
  logic signed [15:0] box_a_ctr[3] = '{default: '0};
  logic        [14:0] box_a_half[3] = '{default: '0};

  contact_t pending_contacts[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  swept_aabb_intersection_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [IN_W-1:0] pack_box(box_in_t b);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 3; i++) begin
      d[16*i +: 16]      = b.ctr[i];
      d[48 + 15*i +: 15] = b.half[i];
      d[93 + 16*i +: 16] = b.vel[i];
    end
    return d;
  endfunction

  // Time at which a gap closes at the given speed, truncated, capped at 1.0.
  function automatic longint gap_time(longint gap, longint speed);
    longint q;
    q = (gap <<< 16) / speed;
    return (q > TIME_ONE) ? TIME_ONE : q;
  endfunction

  // Slab test: the contact interval starts at [0,1] and each axis narrows it.
  function automatic contact_t sweep_contact(box_in_t b);
    longint amin, amax, bmin, bmax, ac, ah, bc, bh, v, d, t0, t1;
    bit overlap, hit;
    contact_t r;
    overlap = 1'b1;
    hit = 1'b1;
    t0 = 0;
    t1 = TIME_ONE;
    for (int i = 0; i < 3; i++) begin
      ac = longint'(box_a_ctr[i]);
      bc = longint'(b.ctr[i]);
      ah = longint'({1'b0, box_a_half[i]});
      bh = longint'({1'b0, b.half[i]});
      d = (ac > bc) ? ac - bc : bc - ac;
      if (d > ah + bh) overlap = 1'b0;
    end
    if (overlap) begin
      r = '{hit: 1'b1, t_first: '0, t_last: '0};
      return r;
    end
    for (int i = 0; i < 3 && hit; i++) begin
      ac = longint'(box_a_ctr[i]);
      bc = longint'(b.ctr[i]);
      ah = longint'({1'b0, box_a_half[i]});
      bh = longint'({1'b0, b.half[i]});
      v = longint'(b.vel[i]);
      amin = ac - ah;
      amax = ac + ah;
      bmin = bc - bh;
      bmax = bc + bh;
      if (v < 0) begin
        // B moves toward negative coordinates; B entirely below A is moving apart.
        if (bmax < amin) hit = 1'b0;
        else begin
          if (amax < bmin && gap_time(bmin - amax, -v) > t0) t0 = gap_time(bmin - amax, -v);
          if (bmax > amin && gap_time(bmax - amin, -v) < t1) t1 = gap_time(bmax - amin, -v);
        end
      end else if (v > 0) begin
        if (bmin > amax) hit = 1'b0;
        else begin
          if (bmax < amin && gap_time(amin - bmax, v) > t0) t0 = gap_time(amin - bmax, v);
          if (amax > bmin && gap_time(amax - bmin, v) < t1) t1 = gap_time(amax - bmin, v);
        end
      end else if (bmax < amin || bmin > amax) begin
        // A still axis that is already separated can never close.
        hit = 1'b0;
      end
      if (t0 > t1) hit = 1'b0;
    end
    if (hit) r = '{hit: 1'b1, t_first: t0[16:0], t_last: t1[16:0]};
    else r = '{hit: 1'b0, t_first: '0, t_last: '0};
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offers one box, honoring the sender idle rate, and returns once it transfers.
  // The expectation is queued at the accepting edge, when box A is stable.
  task automatic send_box(box_in_t b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pack_box(b);
    do @(posedge clk); while (!in_tready);
    pending_contacts.push_back(sweep_contact(b));
  endtask

  // Register write while the core is idle. Upper bits carry junk on purpose,
  // since the core must ignore anything above each field's width.
  task automatic write_reg(sad_reg_t idx, logic [15:0] val);
    logic [31:0] word;
    word = {16'($urandom), val};
    if (idx == REG_A_HALF_X || idx == REG_A_HALF_Y || idx == REG_A_HALF_Z)
      word[15] = 1'($urandom);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_A_CENTER_X: box_a_ctr[0] = word[15:0];
      REG_A_CENTER_Y: box_a_ctr[1] = word[15:0];
      REG_A_CENTER_Z: box_a_ctr[2] = word[15:0];
      REG_A_HALF_X:   box_a_half[0] = word[14:0];
      REG_A_HALF_Y:   box_a_half[1] = word[14:0];
      default:        box_a_half[2] = word[14:0];
    endcase
  endtask

  // Drains the pipeline, then moves box A. This is also the point where the
  // sender pauses until every expected result has come back.
  task automatic place_box_a(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                             logic [15:0] hx, logic [15:0] hy, logic [15:0] hz);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_contacts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(REG_A_CENTER_X, cx);
    write_reg(REG_A_CENTER_Y, cy);
    write_reg(REG_A_CENTER_Z, cz);
    write_reg(REG_A_HALF_X, hx);
    write_reg(REG_A_HALF_Y, hy);
    write_reg(REG_A_HALF_Z, hz);
  endtask

  function automatic box_in_t make_box(logic signed [15:0] x, logic signed [15:0] y,
                                       logic signed [15:0] z, logic [14:0] h,
                                       logic signed [15:0] vx, logic signed [15:0] vy,
                                       logic signed [15:0] vz);
    box_in_t b;
    b.ctr = '{x, y, z};
    b.half = '{h, h, h};
    b.vel = '{vx, vy, vz};
    return b;
  endfunction

  // Mostly boxes aimed at A with a random size scale, so that the clipping
  // arithmetic is exercised; the rest are fully random words.
  function automatic box_in_t random_box();
    box_in_t b;
    int span, off;
    if ($urandom_range(0, 99) < 25) begin
      for (int i = 0; i < 3; i++) begin
        b.ctr[i] = 16'($urandom);
        b.half[i] = 15'($urandom);
        b.vel[i] = 16'($urandom);
      end
      return b;
    end
    case ($urandom_range(0, 3))
      0: span = 64;
      1: span = 1024;
      2: span = 8192;
      default: span = 40000;
    endcase
    for (int i = 0; i < 3; i++) begin
      off = int'($urandom_range(0, 2 * span)) - span;
      b.ctr[i] = 16'(int'(box_a_ctr[i]) + off);
      b.half[i] = 15'($urandom_range(0, span / 2));
      if ($urandom_range(0, 99) < 12) b.vel[i] = '0;
      else b.vel[i] = 16'(-off + int'($urandom_range(0, span / 2)) - span / 4);
    end
    return b;
  endfunction

  task automatic send_random(int count);
    repeat (count) send_box(random_box());
  endtask

  // Receiver: either a long hold-off or a random stall per cycle.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Every result transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    contact_t want;
    contact_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{hit: out_tdata[0], t_first: out_tdata[17:1], t_last: out_tdata[34:18]};
      if (pending_contacts.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
      end else begin
        want = pending_contacts.pop_front();
        if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
        if (got.t_first !== want.t_first) report_mismatch("t_first", got.t_first, want.t_first);
        if (got.t_last !== want.t_last) report_mismatch("t_last", got.t_last, want.t_last);
      end
    end
  end

  // Watchdog on cycles with no transfer on any port.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog expired", $realtime);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hand-picked cases against a cube of half size 100 at the origin.
  task automatic test_directed();
    place_box_a(16'sd0, 16'sd0, 16'sd0, 16'd100, 16'd100, 16'd100);
    send_box(make_box(0, 0, 0, 0, 0, 0, 0));                 // already overlapping
    send_box(make_box(150, 0, 0, 50, 0, 0, 0));              // touching faces at rest
    send_box(make_box(300, 0, 0, 50, -400, 0, 0));           // closing along x
    send_box(make_box(300, 0, 0, 50, 400, 0, 0));            // moving apart
    send_box(make_box(300, 0, 0, 50, 0, 0, 0));              // separated, still
    send_box(make_box(300, 0, 0, 50, -150, 0, 0));           // touches exactly at 1.0
    send_box(make_box(300, 0, 0, 50, -100, 0, 0));           // too slow to reach
    send_box(make_box(-300, 0, 0, 50, 32767, 0, 0));         // fastest positive
    send_box(make_box(300, 0, 0, 50, -32768, 0, 0));         // fastest negative
    send_box(make_box(300, -300, 0, 50, -200, 1000, 0));     // empty interval
    send_box(make_box(300, 300, 300, 50, -400, -400, -400)); // diagonal approach
    send_box(make_box(-32768, -32768, -32768, 15'h7fff, 0, 0, 0));
    send_box(make_box(32767, 32767, 32767, 15'h7fff, 0, 0, 0));
    send_box(make_box(32767, 0, 0, 0, -32768, 0, 0));
    send_box(make_box(-32768, 0, 0, 0, 32767, 0, 0));
    send_box(make_box(0, 32767, 0, 0, 0, -32768, 0));
    send_box(make_box(0, 0, -32768, 0, 0, 0, 32767));
    send_box(make_box(16'sh5555, 16'shaaaa, 16'sh5555, 15'h2aaa,
                      16'shaaaa, 16'sh5555, 16'shaaaa));
    // Box A at the extremes of its registers.
    place_box_a(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'd0, 16'h7fff);
    send_box(make_box(32767, 32767, 32767, 15'h7fff, -32768, -32768, -32768));
    send_box(make_box(-32768, -32768, -32768, 0, 32767, 32767, 32767));
    send_box(make_box(0, 32700, 0, 10, 0, 100, 0));
    send_box(make_box(0, 32767, 0, 0, 0, 0, 0));
  endtask

  task automatic test_streaming_no_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    place_box_a(16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                16'($urandom_range(0, 2000)));
    send_random(250);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 64;
    recv_stall_pct = 0;
    place_box_a(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'd0);
    send_random(250);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 64;
    place_box_a(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_random(250);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 13;
    recv_stall_pct = 13;
    place_box_a(16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
    send_random(250);
  endtask

  // Long receiver hold-off while the sender keeps offering, so the pipeline
  // fills and in_tready must drop until results drain again.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    place_box_a(16'd1000, 16'hfc18, 16'd0, 16'd500, 16'd500, 16'd500);
    hold_left = 400;
    send_random(150);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_streaming_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
